/* sv/char_lcd_command_sequencer_assert.svh */
// Assertion macros used by the character-LCD command sequencer controller.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LCDSEQ_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("char LCD sequencer check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LCDSEQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("char LCD sequencer check failed");
`else
`define LCDSEQ_ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define LCDSEQ_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* sv/lcdseq_pkg.sv */
// Types, codes and constants shared by the character-LCD command sequencer.
`default_nettype none

package lcdseq_pkg;

    // Command codes carried in the op field.
    typedef enum logic [3:0] {
        OP_INIT      = 4'd0,
        OP_CLEAR     = 4'd1,
        OP_HOME      = 4'd2,
        OP_CHAR      = 4'd3,
        OP_DISPLAY   = 4'd4,
        OP_BACKLIGHT = 4'd5,
        OP_BLINK     = 4'd6,
        OP_CURSOR    = 4'd7,
        OP_DIRECTION = 4'd8,
        OP_SHIFT     = 4'd9,
        OP_MOVECUR   = 4'd10,
        OP_MOVEDISP  = 4'd11,
        OP_GOTO      = 4'd12
    } op_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EIGHT_BIT_MODE = 2'd0;
    localparam logic [1:0] CFG_TWO_LINE_MODE  = 2'd1;
    localparam logic [1:0] CFG_TALL_FONT      = 2'd2;

    localparam int MAX_MOVE_COUNT_DEF = 15;

    // Pin word layout.
    localparam int PIN_RS        = 9;
    localparam int PIN_E         = 10;
    localparam int PIN_BACKLIGHT = 11;
    localparam logic [11:0] PIN_KEEP_MASK = 12'hC00;
    localparam logic [11:0] WAKE_DATA     = 12'h030;
    localparam logic [11:0] NIBBLE_DATA   = 12'h020;

    // Delays in microseconds.
    localparam logic [15:0] WAIT_POWER_UP = 16'd41000;
    localparam logic [15:0] WAIT_WAKE_2   = 16'd5000;
    localparam logic [15:0] WAIT_WAKE_3   = 16'd101;
    localparam logic [15:0] WAIT_PULSE    = 16'd2;
    localparam logic [15:0] WAIT_CMD      = 16'd38;
    localparam logic [15:0] WAIT_LONG     = 16'd2000;

    // Bit positions inside the kept command bytes.
    localparam int DC_BLINK    = 0;
    localparam int DC_CURSOR   = 1;
    localparam int DC_DISPLAY  = 2;
    localparam int EM_SHIFT    = 0;
    localparam int EM_INC      = 1;
    localparam int SH_RIGHT    = 2;
    localparam int SH_SCREEN   = 3;

    localparam logic [7:0] ENTRY_RESET   = 8'h06;
    localparam logic [7:0] DCTRL_RESET   = 8'h0C;
    localparam logic [7:0] SHIFT_RESET   = 8'h14;
    localparam logic [7:0] INS_CLEAR_B   = 8'h01;
    localparam logic [7:0] INS_HOME_B    = 8'h02;
    localparam logic [7:0] FSET_BASE     = 8'h20;
    localparam logic [7:0] FSET_8BIT     = 8'h10;
    localparam logic [7:0] FSET_2LINE    = 8'h08;
    localparam logic [7:0] FSET_TALL     = 8'h04;
    localparam logic [7:0] SET_ADDR_B    = 8'h80;
    localparam logic [6:0] LINE2_OFFSET  = 7'h40;
    localparam logic [6:0] MAX_COL_2LINE = 7'd39;
    localparam logic [6:0] MAX_COL_1LINE = 7'd79;

    // Controller counter marks.
    localparam logic [3:0] WAKE_LAST = 4'd2;
    localparam logic [3:0] INIT_LAST = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAKE,
        ST_NIBBLE,
        ST_INIT_ISSUE,
        ST_ISSUE,
        ST_MOVE,
        ST_LIGHT
    } state_t;

    // Which instruction the datapath builds.
    typedef enum logic [3:0] {
        INS_FSET,
        INS_DC_OFF,
        INS_DC,
        INS_CLEAR,
        INS_HOME,
        INS_CHAR,
        INS_ENTRY,
        INS_SHIFT,
        INS_GOTO
    } ins_sel_t;

    // How the pin word is loaded before a word goes out.
    typedef enum logic [2:0] {
        LD_KEEP,
        LD_WAKE,
        LD_NIBBLE,
        LD_FULL,
        LD_HI,
        LD_LO,
        LD_LIGHT
    } load_t;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_POWER,
        PRE_WAKE2,
        PRE_WAKE3
    } pre_t;

    typedef enum logic [1:0] {
        POST_NONE,
        POST_CMD,
        POST_LONG
    } post_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] value;
        logic       direction;
        logic [3:0] count;
        logic [6:0] column;
        logic [1:0] line;
    } in_word_t;

    typedef struct packed {
        logic [11:0] pins;
        logic [15:0] wait_before_us;
        logic        last;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic     capture;
        logic     emit;
        logic     e_high;
        logic     set_e;
        load_t    load;
        pre_t     pre;
        post_t    post;
        ins_sel_t ins_sel;
        logic     last;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic wide_bus;
    } dp_status_t;

    // Instruction order of the init sequence after the wake pulses.
    function automatic ins_sel_t init_ins(input logic [3:0] idx);
        ins_sel_t r;
        case (idx)
            4'd0:    r = INS_FSET;
            4'd1:    r = INS_DC_OFF;
            4'd2:    r = INS_CLEAR;
            4'd3:    r = INS_ENTRY;
            default: r = INS_DC;
        endcase
        return r;
    endfunction

    // Clear and home need the long settle time.
    function automatic post_t post_for(input ins_sel_t s);
        post_t r;
        case (s)
            INS_CLEAR, INS_HOME: r = POST_LONG;
            default:             r = POST_CMD;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/lcdseq_ctrl.sv */
// Controller state machine that steps through enable pulses for LCD instructions.
`default_nettype none
`include "char_lcd_command_sequencer_assert.svh"

module lcdseq_ctrl
    import lcdseq_pkg::*;
#(
    parameter int MAX_MOVE_COUNT = MAX_MOVE_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [3:0] in_op,
    input  logic [3:0] in_count,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] MaxCnt = 4'(MAX_MOVE_COUNT);

    state_t     state_reg, state_next;
    logic       phase_reg, phase_next;   // 0: E-high word next, 1: E-low word next
    logic       nib_reg, nib_next;       // 0: upper nibble, 1: lower nibble
    logic [3:0] cnt_reg, cnt_next;
    ins_sel_t   ins_sel_reg, ins_sel_next;

    ins_sel_t   cur_ins;
    load_t      issue_load;
    logic       issue_end;
    logic       final_issue;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            nib_reg     <= 1'b0;
            cnt_reg     <= '0;
            ins_sel_reg <= INS_CLEAR;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            nib_reg     <= nib_next;
            cnt_reg     <= cnt_next;
            ins_sel_reg <= ins_sel_next;
        end
    end

    // Instruction in flight and how its pulses are loaded.
    always_comb
    begin
        case (state_reg)
            ST_INIT_ISSUE: cur_ins = init_ins(cnt_reg);
            ST_MOVE:       cur_ins = INS_SHIFT;
            default:       cur_ins = ins_sel_reg;
        endcase
        issue_load  = status.wide_bus ? LD_FULL : (nib_reg ? LD_LO : LD_HI);
        issue_end   = status.wide_bus | nib_reg;
        final_issue = (state_reg == ST_ISSUE) ||
                      ((state_reg == ST_INIT_ISSUE) && (cnt_reg == INIT_LAST)) ||
                      ((state_reg == ST_MOVE) && (cnt_reg == 4'd1));
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        nib_next     = nib_reg;
        cnt_next     = cnt_reg;
        ins_sel_next = ins_sel_reg;
        in_stall     = (state_reg != ST_IDLE);

        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        cmd.e_high  = !phase_reg;
        cmd.set_e   = 1'b1;
        cmd.load    = LD_KEEP;
        cmd.pre     = PRE_NONE;
        cmd.post    = POST_NONE;
        cmd.ins_sel = cur_ins;
        cmd.last    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    phase_next  = 1'b0;
                    nib_next    = 1'b0;
                    case (in_op)
                        OP_INIT:
                        begin
                            state_next = ST_WAKE;
                            cnt_next   = '0;
                        end
                        OP_CLEAR:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_CLEAR;
                        end
                        OP_HOME:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_HOME;
                        end
                        OP_CHAR:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_CHAR;
                        end
                        OP_DISPLAY, OP_BLINK, OP_CURSOR:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_DC;
                        end
                        OP_DIRECTION, OP_SHIFT:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_ENTRY;
                        end
                        OP_GOTO:
                        begin
                            state_next   = ST_ISSUE;
                            ins_sel_next = INS_GOTO;
                        end
                        OP_BACKLIGHT:
                        begin
                            state_next = ST_LIGHT;
                        end
                        OP_MOVECUR, OP_MOVEDISP:
                        begin
                            // A zero count only updates the shift byte.
                            if (in_count != 4'd0)
                            begin
                                state_next = ST_MOVE;
                                cnt_next   = (in_count > MaxCnt) ? MaxCnt : in_count;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WAKE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!phase_reg)
                    begin
                        cmd.load = LD_WAKE;
                        case (cnt_reg)
                            4'd0:    cmd.pre = PRE_POWER;
                            4'd1:    cmd.pre = PRE_WAKE2;
                            default: cmd.pre = PRE_WAKE3;
                        endcase
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (cnt_reg == WAKE_LAST)
                        begin
                            cnt_next   = '0;
                            state_next = status.wide_bus ? ST_INIT_ISSUE : ST_NIBBLE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                end
            end

            ST_NIBBLE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!phase_reg)
                    begin
                        cmd.load   = LD_NIBBLE;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_INIT_ISSUE;
                    end
                end
            end

            ST_INIT_ISSUE, ST_ISSUE, ST_MOVE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!phase_reg)
                    begin
                        cmd.load   = issue_load;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (!issue_end)
                        begin
                            nib_next = 1'b1;
                        end
                        else
                        begin
                            nib_next = 1'b0;
                            cmd.post = post_for(cur_ins);
                            if (final_issue)
                            begin
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else if (state_reg == ST_MOVE)
                            begin
                                cnt_next = cnt_reg - 4'd1;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                    end
                end
            end

            ST_LIGHT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.load   = LD_LIGHT;
                    cmd.set_e  = 1'b0;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A word is only produced when the output register can take it.
    `LCDSEQ_ASSERT_IMPLIES(a_emit_needs_room, clk, rst_n, cmd.emit, status.out_free)
    // Nothing goes out while waiting for a command.
    `LCDSEQ_ASSERT_IMPLIES(a_idle_quiet, clk, rst_n, state_reg == ST_IDLE, !cmd.emit)
    // The init instruction index never runs past the last init instruction.
    `LCDSEQ_ASSERT_IMPLIES(a_init_index, clk, rst_n, state_reg == ST_INIT_ISSUE,
                           cnt_reg <= INIT_LAST)
    // The final word of a command returns the controller to idle.
    `LCDSEQ_ASSERT_NEXT(a_last_ends, clk, rst_n, cmd.emit && cmd.last,
                        state_reg == ST_IDLE)

endmodule

`default_nettype wire

/* sv/lcdseq_dp.sv */
// Datapath: configuration, kept command bytes, pin word, wait accumulator, output register.
`default_nettype none

module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  in_word_t   in_word,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_word
);

    logic        wide_bus_reg, two_line_reg, tall_font_reg;
    logic [11:0] pin_reg, pin_next;
    logic [15:0] pending_reg, pending_next;
    logic [7:0]  entry_reg, entry_next;
    logic [7:0]  dctrl_reg, dctrl_next;
    logic [7:0]  shcmd_reg, shcmd_next;
    logic [7:0]  value_reg;
    logic [6:0]  column_reg;
    logic [1:0]  line_reg;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    logic [9:0]  ins;
    logic [7:0]  fset;
    logic [6:0]  col_clamped;
    logic [6:0]  addr;
    logic [15:0] pre_amt;
    logic [15:0] post_amt;
    logic [16:0] pre_sum;
    logic [15:0] emit_wait;
    logic        en;

    assign en = value_reg[0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_bus_reg  <= 1'b0;
            two_line_reg  <= 1'b0;
            tall_font_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EIGHT_BIT_MODE: wide_bus_reg  <= cfg_data;
                CFG_TWO_LINE_MODE:  two_line_reg  <= cfg_data;
                CFG_TALL_FONT:      tall_font_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Command fields kept for instruction building.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg  <= in_word.value;
            column_reg <= in_word.column;
            line_reg   <= in_word.line;
        end
    end

    // Kept command bytes change when a command is taken.
    always_comb
    begin
        entry_next = entry_reg;
        dctrl_next = dctrl_reg;
        shcmd_next = shcmd_reg;
        if (cmd.capture)
        begin
            case (in_word.op)
                OP_INIT:      dctrl_next[DC_DISPLAY] = 1'b1;
                OP_DISPLAY:   dctrl_next[DC_DISPLAY] = in_word.value[0];
                OP_BLINK:     dctrl_next[DC_BLINK]   = in_word.value[0];
                OP_CURSOR:    dctrl_next[DC_CURSOR]  = in_word.value[0];
                OP_DIRECTION: entry_next[EM_INC]     = in_word.direction;
                OP_SHIFT:     entry_next[EM_SHIFT]   = in_word.value[0];
                OP_MOVECUR:
                begin
                    shcmd_next[SH_RIGHT]  = in_word.direction;
                    shcmd_next[SH_SCREEN] = 1'b0;
                end
                OP_MOVEDISP:
                begin
                    shcmd_next[SH_RIGHT]  = in_word.direction;
                    shcmd_next[SH_SCREEN] = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Function set byte and clamped cursor address.
    always_comb
    begin
        fset = FSET_BASE;
        if (two_line_reg)
            fset = fset | FSET_2LINE;
        else if (tall_font_reg)
            fset = fset | FSET_TALL;
        if (wide_bus_reg)
            fset = fset | FSET_8BIT;

        if (two_line_reg)
            col_clamped = (column_reg > MAX_COL_2LINE) ? MAX_COL_2LINE : column_reg;
        else
            col_clamped = (column_reg > MAX_COL_1LINE) ? MAX_COL_1LINE : column_reg;
        addr = (two_line_reg && (line_reg != 2'd0)) ? (col_clamped | LINE2_OFFSET)
                                                     : col_clamped;
    end

    // Instruction word: RS in bit 9 over the eight data bits.
    always_comb
    begin
        case (cmd.ins_sel)
            INS_FSET:   ins = {2'b00, fset};
            INS_DC_OFF: ins = {2'b00, dctrl_reg & ~(8'h01 << DC_DISPLAY)};
            INS_DC:     ins = {2'b00, dctrl_reg};
            INS_CLEAR:  ins = {2'b00, INS_CLEAR_B};
            INS_HOME:   ins = {2'b00, INS_HOME_B};
            INS_CHAR:   ins = {2'b10, value_reg};
            INS_ENTRY:  ins = {2'b00, entry_reg};
            INS_SHIFT:  ins = {2'b00, shcmd_reg};
            INS_GOTO:   ins = {2'b00, SET_ADDR_B | {1'b0, addr}};
            default:    ins = '0;
        endcase
    end

    // Pin word for the next bus word.
    always_comb
    begin
        case (cmd.load)
            LD_WAKE:   pin_next = (pin_reg & PIN_KEEP_MASK) | WAKE_DATA;
            LD_NIBBLE: pin_next = (pin_reg & PIN_KEEP_MASK) | NIBBLE_DATA;
            LD_FULL:   pin_next = {pin_reg[11:10], ins};
            LD_HI:     pin_next = {pin_reg[11:10], ins[9:8], ins[7:4], 4'b0000};
            LD_LO:     pin_next = {pin_reg[11:10], ins[9:8], ins[3:0], 4'b0000};
            LD_LIGHT:  pin_next = {en, pin_reg[10:0]};
            default:   pin_next = pin_reg;
        endcase
        if (cmd.set_e)
            pin_next[PIN_E] = cmd.e_high;
    end

    // Wait before this word, saturating, and what is owed to the next one.
    always_comb
    begin
        case (cmd.pre)
            PRE_POWER: pre_amt = WAIT_POWER_UP;
            PRE_WAKE2: pre_amt = WAIT_WAKE_2;
            PRE_WAKE3: pre_amt = WAIT_WAKE_3;
            default:   pre_amt = '0;
        endcase
        case (cmd.post)
            POST_CMD:  post_amt = WAIT_CMD;
            POST_LONG: post_amt = WAIT_LONG;
            default:   post_amt = '0;
        endcase
        pre_sum   = {1'b0, pending_reg} + {1'b0, pre_amt};
        emit_wait = pre_sum[16] ? 16'hFFFF : pre_sum[15:0];

        if (cmd.load == LD_LIGHT)
            pending_next = '0;
        else if (cmd.e_high)
            pending_next = WAIT_PULSE;
        else
            pending_next = WAIT_PULSE + post_amt;

        out_word_next.pins           = pin_next;
        out_word_next.wait_before_us = emit_wait;
        out_word_next.last           = cmd.last;
    end

    // Pin word, pending wait and command bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg     <= '0;
            pending_reg <= '0;
            entry_reg   <= ENTRY_RESET;
            dctrl_reg   <= DCTRL_RESET;
            shcmd_reg   <= SHIFT_RESET;
        end
        else
        begin
            entry_reg <= entry_next;
            dctrl_reg <= dctrl_next;
            shcmd_reg <= shcmd_next;
            if (cmd.emit)
            begin
                pin_reg     <= pin_next;
                pending_reg <= pending_next;
            end
        end
    end

    // Output register: holds a word until the receiver takes it.
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_word_reg <= out_word_next;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.wide_bus = wide_bus_reg;
    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;

endmodule

`default_nettype wire

/* sv/char_lcd_command_sequencer.sv */
// Top level of the character-LCD command sequencer: controller plus datapath.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall  | op, value, direction, count, column, line
//  out     | output    | out_valid/out_stall| pins, wait_before_us, last
//  cfg     | input     | cfg_write          | cfg_index, cfg_data (no read-back)
//
// A command is taken, then its pin words leave at one per cycle while the output is
// not stalled: init gives 16 words in 8-bit mode and 28 in 4-bit mode, a move up to
// 60 in 4-bit mode. The output register sets this rate; out_stall holds the controller
// in place. in_stall is high from the cycle after a command that emits words is taken
// until its last word is registered. Reset clears the pin word and pending wait and
// loads the command bytes with their reset values at once.
`default_nettype none

module char_lcd_command_sequencer
    import lcdseq_pkg::*;
#(
    parameter int MAX_MOVE_COUNT = MAX_MOVE_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_word,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lcdseq_ctrl #(
        .MAX_MOVE_COUNT(MAX_MOVE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_word.op),
        .in_count (in_word.count),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lcdseq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
